/* sv/crcpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked page receiver: shared definitions
// Frame geometry, command and result codes, the command word that passes
// from the front end to the back end, and the CRC-16/XMODEM byte update.
// ----------------------------------------------------------------------------
package crcpr_pkg;

    localparam int WORDS_PER_PAGE = 32;
    localparam int MAX_PAGES      = 52;
    localparam int DATA_BYTES     = 2 * WORDS_PER_PAGE;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int WORD_W      = IDX_W - 1;
    localparam int COUNT_W     = 7;
    localparam int ADDR_W      = 13;

    // Commands from the front end to the back end.
    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_ERROR  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Result kinds on the output channel.
    localparam logic [1:0] RK_WRITE  = 2'd0;
    localparam logic [1:0] RK_ERROR  = 2'd1;
    localparam logic [1:0] RK_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data;     // byte to store, or page number for a write
        logic [IDX_W-1:0] idx;      // store position for OP_STORE
        logic             is_last;  // the page is the final application page
    } t_cmd;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* sv/crcpr_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked page receiver: channel interfaces
// Valid/ready channels for received words and for result words.
// ----------------------------------------------------------------------------
interface crcpr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface crcpr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [12:0] word_address;
    logic [15:0] word_value;
    logic        erase_first;
    logic        finished;
    logic        last;

    modport source (output valid, output result_kind, output word_address,
                    output word_value, output erase_first, output finished,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input word_address,
                    input word_value, input erase_first, input finished,
                    input last, output ready);
endinterface

/* sv/crcpr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked page receiver: front end
// Tracks the frame position and running CRC, checks the completed frame and
// issues store, write, error and finish commands to the back end.
// ----------------------------------------------------------------------------
module crcpr_front
    import crcpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    crcpr_in_if.sink     i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_page, n_page;
    logic [7:0]         r_crc_lo, n_crc_lo;
    logic [7:0]         r_expected, n_expected;
    logic               r_done, n_done;

    logic               w_accept;
    logic [15:0]        w_rx_crc;
    logic               w_is_last;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_rx_crc   = {i_in.data_byte, r_crc_lo};
    assign w_is_last  = (r_page == 8'(MAX_PAGES - 1));

    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_page     = r_page;
        n_crc_lo   = r_crc_lo;
        n_expected = r_expected;
        n_done     = r_done;
        o_push     = 1'b0;
        o_cmd      = '{op: OP_STORE, data: i_in.data_byte,
                       idx: r_count[IDX_W-1:0], is_last: w_is_last};

        // Once the last page is through, everything is dropped until reset.
        if (w_accept && !r_done) begin
            if (i_in.kind) begin
                n_count = '0;
                n_crc   = '0;
            end else if (r_count < COUNT_W'(DATA_BYTES)) begin
                o_push  = 1'b1;
                n_crc   = crc_step(r_crc, i_in.data_byte);
                n_count = r_count + 1'b1;
            end else if (r_count == COUNT_W'(DATA_BYTES)) begin
                n_page  = i_in.data_byte;
                n_crc   = crc_step(r_crc, i_in.data_byte);
                n_count = r_count + 1'b1;
            end else if (r_count == COUNT_W'(DATA_BYTES + 1)) begin
                n_crc_lo = i_in.data_byte;
                n_count  = r_count + 1'b1;
            end else begin
                // High CRC byte: the frame is complete.
                n_count = '0;
                n_crc   = '0;
                if (r_page < 8'(MAX_PAGES)) begin
                    if (r_crc != w_rx_crc) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_ERROR;
                    end else begin
                        if (r_page == r_expected) begin
                            o_push     = 1'b1;
                            o_cmd.op   = OP_WRITE;
                            o_cmd.data = r_page;
                            n_expected = r_expected + 1'b1;
                        end else if (w_is_last) begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_FINISH;
                        end
                        if (w_is_last) begin
                            n_done = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= '0;
            r_page     <= '0;
            r_crc_lo   <= '0;
            r_expected <= '0;
            r_done     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_page     <= n_page;
            r_crc_lo   <= n_crc_lo;
            r_expected <= n_expected;
            r_done     <= n_done;
        end
    end

endmodule

/* sv/crcpr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked page receiver: command queue
// Two-entry first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module crcpr_queue
    import crcpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd       r_entry [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;

    assign o_cmd   = r_entry[r_rp];
    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

/* sv/crcpr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked page receiver: back end
// Holds the frame store and carries out commands: stores data bytes, plays
// out a page as word writes, and raises error and finish words.
// ----------------------------------------------------------------------------
module crcpr_back
    import crcpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    input  logic         i_empty,
    output logic         o_pop,
    crcpr_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [7:0]        r_mem [0:STORE_DEPTH-1];
    logic [7:0]        r_rd_lo;
    logic [7:0]        r_rd_hi;

    logic [1:0]        r_state, n_state;
    logic [WORD_W-1:0] r_word, n_word;
    logic [7:0]        r_page, n_page;
    logic              r_is_last, n_is_last;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [15:0]       r_value, n_value;
    logic              r_erase, n_erase;
    logic              r_fin, n_fin;
    logic              r_last, n_last;

    logic              w_out_free;
    logic              w_mem_we;
    logic              w_last_word;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_last_word = (r_word == WORD_W'(WORDS_PER_PAGE - 1));

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_kind;
    assign o_out.word_address = r_addr;
    assign o_out.word_value   = r_value;
    assign o_out.erase_first  = r_erase;
    assign o_out.finished     = r_fin;
    assign o_out.last         = r_last;

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_page      = r_page;
        n_is_last   = r_is_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_value     = r_value;
        n_erase     = r_erase;
        n_fin       = r_fin;
        n_last      = r_last;
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        OP_STORE: begin
                            w_mem_we = 1'b1;
                            o_pop    = 1'b1;
                        end
                        OP_WRITE: begin
                            o_pop     = 1'b1;
                            n_page    = i_cmd.data;
                            n_is_last = i_cmd.is_last;
                            n_word    = '0;
                            n_state   = S_READ;
                        end
                        OP_ERROR, OP_FINISH: begin
                            if (w_out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_kind      = (i_cmd.op == OP_ERROR) ? RK_ERROR : RK_FINISH;
                                n_addr      = '0;
                                n_value     = '0;
                                n_erase     = 1'b0;
                                n_fin       = (i_cmd.op == OP_FINISH);
                                n_last      = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // Both bytes of the word are read here and land in r_rd_lo/hi.
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = RK_WRITE;
                    n_addr      = ADDR_W'(r_page) * ADDR_W'(WORDS_PER_PAGE) + ADDR_W'(r_word);
                    n_value     = {r_rd_hi, r_rd_lo};
                    n_erase     = (r_word == '0);
                    n_fin       = w_last_word && r_is_last;
                    n_last      = w_last_word;
                    if (w_last_word) begin
                        n_state = S_IDLE;
                    end else begin
                        n_word  = r_word + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_cmd.idx] <= i_cmd.data;
        end
        if (r_state == S_READ) begin
            r_rd_lo <= r_mem[{r_word, 1'b0}];
            r_rd_hi <= r_mem[{r_word, 1'b1}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_word    <= n_word;
        r_page    <= n_page;
        r_is_last <= n_is_last;
        r_kind    <= n_kind;
        r_addr    <= n_addr;
        r_value   <= n_value;
        r_erase   <= n_erase;
        r_fin     <= n_fin;
        r_last    <= n_last;
    end

endmodule

/* sv/crc_checked_page_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked page receiver
// Gathers received bytes into page frames, checks the CRC-16/XMODEM and
// turns a good, expected page into a burst of flash word writes.
//
//   Channel  Dir  Carries
//   i_in     in   kind (data byte or break), data_byte
//   o_out    out  result_kind, word_address, word_value, erase_first,
//                 finished, last
//
// A received word is taken whenever the two-entry command queue has room.
// A good page plays out word by word, each word a frame store read (S_READ)
// and then an output load (S_EMIT); no new command is taken until the page
// is done. A stalled output holds the back end, and the front end stalls
// only once the queue fills. Synchronous reset clears all control state;
// the frame store is not cleared and is always filled before use.
// ----------------------------------------------------------------------------
module crc_checked_page_receiver_unit
    import crcpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    crcpr_in_if.sink     i_in,
    crcpr_out_if.source  o_out
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    crcpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    crcpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    crcpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

/* sim/tb_crc_checked_page_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: CRC-checked page receiver
// Sends framed pages, breaks and damaged frames through the receive channel.
// A built-in tracker of the frame state predicts every flash write, error and
// finish word, which are checked field by field at the output channel.
// ----------------------------------------------------------------------------
module tb_crc_checked_page_receiver_unit;
    import crcpr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 4 * WORDS_PER_PAGE;
    localparam logic [7:0] LAST_PAGE = 8'(MAX_PAGES - 1);

    // Data patterns for the words of a page.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;
    localparam int FILL_CHECK  = 3;
    localparam int FILL_RAMP   = 4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       value;
        logic              erase;
        logic              fin;
        logic              last;
    } t_result_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crcpr_in_if  in_if();
    crcpr_out_if out_if();

    crc_checked_page_receiver_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // Tracked receiver state.
    logic [7:0]         frame_bytes [STORE_DEPTH];
    logic [7:0]         page_byte;
    logic [15:0]        rx_crc;
    logic [COUNT_W-1:0] byte_cnt;
    logic [15:0]        run_crc;
    logic [7:0]         next_page;
    logic               update_over;

    t_result_word due_words [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           calm = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [15:0] xmodem_crc_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = c << 1;
            if (fb) begin
                c = c ^ 16'h1021;
            end
        end
        return c;
    endfunction

    function automatic void clear_tracker();
        byte_cnt    = '0;
        run_crc     = '0;
        rx_crc      = '0;
        page_byte   = '0;
        next_page   = '0;
        update_over = 1'b0;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input int addr,
                                        input logic [15:0] value, input logic erase,
                                        input logic fin, input logic last);
        t_result_word r;
        r.kind  = kind;
        r.addr  = ADDR_W'(addr);
        r.value = value;
        r.erase = erase;
        r.fin   = fin;
        r.last  = last;
        due_words.push_back(r);
    endfunction

    // Advance the tracked frame state by one accepted word and queue the
    // results it causes.
    function automatic void track_received_word(input logic brk, input logic [7:0] b);
        int   page;
        logic at_last;
        logic at_end;
        if (update_over) begin
            return;
        end
        if (brk) begin
            byte_cnt = '0;
            run_crc  = '0;
            return;
        end
        if (byte_cnt < DATA_BYTES) begin
            frame_bytes[byte_cnt[IDX_W-1:0]] = b;
            run_crc  = xmodem_crc_byte(run_crc, b);
            byte_cnt = byte_cnt + 1'b1;
            return;
        end
        if (byte_cnt == DATA_BYTES) begin
            page_byte = b;
            run_crc   = xmodem_crc_byte(run_crc, b);
            byte_cnt  = byte_cnt + 1'b1;
            return;
        end
        if (byte_cnt == DATA_BYTES + 1) begin
            rx_crc   = {8'h00, b};
            byte_cnt = byte_cnt + 1'b1;
            return;
        end
        // The high CRC byte closes the frame.
        rx_crc[15:8] = b;
        byte_cnt     = '0;
        page         = page_byte;
        if (page < MAX_PAGES) begin
            if (run_crc != rx_crc) begin
                push_result(RK_ERROR, 0, 16'h0000, 1'b0, 1'b0, 1'b1);
            end else begin
                at_last = (page == MAX_PAGES - 1);
                if (page_byte == next_page) begin
                    for (int i = 0; i < WORDS_PER_PAGE; i++) begin
                        at_end = (i == WORDS_PER_PAGE - 1);
                        push_result(RK_WRITE, page * WORDS_PER_PAGE + i,
                                    {frame_bytes[2 * i + 1], frame_bytes[2 * i]},
                                    i == 0, at_end && at_last, at_end);
                    end
                    next_page = next_page + 8'd1;
                end else if (at_last) begin
                    push_result(RK_FINISH, 0, 16'h0000, 1'b0, 1'b1, 1'b1);
                end
                if (at_last) begin
                    update_over = 1'b1;
                end
            end
        end
        run_crc = '0;
    endfunction

    // Sends one word; entered and left at a falling edge.
    task automatic send_word(input logic brk, input logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= brk;
        in_if.data_byte <= b;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        track_received_word(brk, b);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] page, input bit spoil, input int fill);
        logic [7:0]  b;
        logic [15:0] crc;
        crc = '0;
        for (int i = 0; i < DATA_BYTES; i++) begin
            case (fill)
                FILL_ZEROS: b = 8'h00;
                FILL_ONES:  b = 8'hFF;
                FILL_CHECK: b = (i % 2 == 0) ? 8'h55 : 8'hAA;
                FILL_RAMP:  b = 8'(i);
                default:    b = 8'($urandom_range(0, 255));
            endcase
            crc = xmodem_crc_byte(crc, b);
            send_word(1'b0, b);
        end
        crc = xmodem_crc_byte(crc, page);
        if (spoil) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_word(1'b0, page);
        send_word(1'b0, crc[7:0]);
        send_word(1'b0, crc[15:8]);
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (due_words.size() != 0);
    endtask

    // Breaks around a partial frame; nothing may come out.
    task automatic test_breaks();
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        repeat (8) send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'hA5);
    endtask

    task automatic test_crc_errors();
        // A damaged frame for page 1 or the last page must not end the update.
        send_frame(($urandom_range(0, 1) == 0) ? 8'd1 : LAST_PAGE, 1'b1,
                   int'($urandom_range(FILL_RANDOM, FILL_RAMP)));
    endtask

    // A good frame that is either out of range or not the expected page.
    task automatic test_ignored_pages();
        logic [7:0] page;
        if ($urandom_range(0, 1) == 0) begin
            page = 8'($urandom_range(MAX_PAGES, 255));
        end else begin
            do begin
                page = 8'($urandom_range(0, MAX_PAGES - 2));
            end while (page == next_page);
        end
        send_frame(page, 1'b0, int'($urandom_range(FILL_RANDOM, FILL_RAMP)));
    endtask

    task automatic test_pressure();
        send_frame(next_page, 1'b0, int'($urandom_range(FILL_RANDOM, FILL_RAMP)));
        wait_for_results();
    endtask

    task automatic test_update_end();
        calm = 1'b1;
        if (!update_over) begin
            send_frame(LAST_PAGE, 1'b0, FILL_RANDOM);
        end
        // Everything after the end of the update is ignored.
        send_word(1'b1, 8'h00);
        repeat (3) send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'hFF);
    endtask

    // Output ready with random stall bursts.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result_word want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, kind %0d",
                                          out_if.result_kind));
            end else begin
                want = due_words.pop_front();
                if (out_if.result_kind !== want.kind)
                    report_mismatch($sformatf("result_kind got %0d expected %0d",
                                              out_if.result_kind, want.kind));
                if (out_if.word_address !== want.addr)
                    report_mismatch($sformatf("word_address got %0h expected %0h",
                                              out_if.word_address, want.addr));
                if (out_if.word_value !== want.value)
                    report_mismatch($sformatf("word_value got %0h expected %0h",
                                              out_if.word_value, want.value));
                if (out_if.erase_first !== want.erase)
                    report_mismatch($sformatf("erase_first got %0b expected %0b",
                                              out_if.erase_first, want.erase));
                if (out_if.finished !== want.fin)
                    report_mismatch($sformatf("finished got %0b expected %0b",
                                              out_if.finished, want.fin));
                if (out_if.last !== want.last)
                    report_mismatch($sformatf("last got %0b expected %0b",
                                              out_if.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.kind      = 1'b0;
        in_if.data_byte = 8'h00;
        clear_tracker();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_breaks();
        test_crc_errors();
        test_ignored_pages();
        test_pressure();
        test_update_end();

        wait_for_results();
        repeat (SETTLE_WAIT) @(negedge i_clk);
        if (due_words.size() != 0) begin
            report_mismatch($sformatf("%0d expected result words never came",
                                      due_words.size()));
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
